FILE: hdl/csv_decimal_field_parser_assert.svh
// assertion macros for the csv decimal field parser
`ifndef CSV_DECIMAL_FIELD_PARSER_ASSERT_SVH
`define CSV_DECIMAL_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define CSVDFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvdfp assertion failed");

// next-cycle implication
`define CSVDFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvdfp assertion failed");

`endif

FILE: hdl/csvdfp_pkg.sv
// shared types and constants of the csv decimal field parser
`default_nettype none

package csvdfp_pkg;

    localparam int MANT_W          = 48;
    localparam int MAX_FRAC_DIGITS = 15;
    localparam int MAX_COLUMNS     = 4096;

    localparam int FRAC_W    = 4;
    localparam int CFG_W     = 13;
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ACC_EXT_W = MANT_W + 4;

    localparam logic [MANT_W-1:0] MAG_LIMIT = {1'b0, {(MANT_W-1){1'b1}}};

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_BAD   = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        TK_EOF,
        TK_COMMA,
        TK_NEWLINE,
        TK_MINUS,
        TK_POINT,
        TK_DIGIT,
        TK_OTHER
    } t_tok_class;

    typedef struct packed {
        t_tok_class cls;
        logic [3:0] digit;
        logic       is_t;
    } t_token;

endpackage

`default_nettype wire

FILE: hdl/csvdfp_if.sv
// byte input and field output channel interfaces
`default_nettype none

interface csvdfp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface csvdfp_out_if import csvdfp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        frac_digits;
    logic [COL_W-1:0]         column_index;
    logic                     row_end;
    logic [1:0]               status;

    modport source (output valid, output mantissa, output frac_digits, output column_index,
                    output row_end, output status, input ready);
    modport sink   (input valid, input mantissa, input frac_digits, input column_index,
                    input row_end, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/csvdfp_front.sv
// front end: accepts bytes and classifies them into tokens
`default_nettype none

module csvdfp_front
    import csvdfp_pkg::*;
(
    csvdfp_in_if.sink  i_byte,
    input  wire logic  i_push_ready,
    output logic       o_push,
    output t_token     o_tok
);

    assign i_byte.ready = i_push_ready;
    assign o_push       = i_byte.valid & i_push_ready;

    always_comb begin
        o_tok.digit = 4'(i_byte.text_byte - CH_ZERO);
        o_tok.is_t  = (i_byte.text_byte == CH_T);
        if (i_byte.kind) begin
            o_tok.cls = TK_EOF;
        end else if (i_byte.text_byte == CH_COMMA) begin
            o_tok.cls = TK_COMMA;
        end else if (i_byte.text_byte == CH_NL) begin
            o_tok.cls = TK_NEWLINE;
        end else if (i_byte.text_byte == CH_MINUS) begin
            o_tok.cls = TK_MINUS;
        end else if (i_byte.text_byte == CH_POINT) begin
            o_tok.cls = TK_POINT;
        end else if (i_byte.text_byte >= CH_ZERO && i_byte.text_byte <= CH_NINE) begin
            o_tok.cls = TK_DIGIT;
        end else begin
            o_tok.cls = TK_OTHER;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/csvdfp_fifo.sv
// short token queue between front and back
`default_nettype none

module csvdfp_fifo
    import csvdfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_token      i_tok,
    output logic             o_push_ready,
    input  wire logic        i_pop,
    output t_token           o_tok,
    output logic             o_tok_valid,
    output logic [CNT_W-1:0] o_count
);

    t_token           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    assign o_tok        = r_mem[r_rd];
    assign o_tok_valid  = (r_count != '0);
    assign o_push_ready = (r_count != CNT_W'(FIFO_DEPTH));
    assign o_count      = r_count;

endmodule

`default_nettype wire

FILE: hdl/csvdfp_back.sv
// back end: field accumulation, column tracking and result register
`default_nettype none

module csvdfp_back
    import csvdfp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire t_token           i_tok,
    input  wire logic             i_tok_valid,
    output logic                  o_pop,
    csvdfp_out_if.source          o_field
);

    logic [COL_W-1:0]  r_last_col;
    logic [COL_W-1:0]  r_col,      n_col;
    logic [MANT_W-1:0] r_acc,      n_acc;
    logic [FRAC_W-1:0] r_frac,     n_frac;
    logic              r_neg,      n_neg;
    logic              r_in_frac,  n_in_frac;
    logic              r_started,  n_started;
    logic              r_first_t,  n_first_t;
    logic              r_err_sat,  n_err_sat;
    logic              r_err_bad,  n_err_bad;

    logic                     r_valid, n_valid;
    logic signed [MANT_W-1:0] r_mant;
    logic [FRAC_W-1:0]        r_frac_out;
    logic [COL_W-1:0]         r_col_out;
    logic                     r_row_end;
    t_status                  r_status;

    logic                 w_is_last;
    logic [ACC_EXT_W-1:0] w_cand;
    logic                 w_emit;
    logic                 w_emit_bool;
    logic                 w_emit_short;
    logic                 w_emit_row_end;
    logic [MANT_W-1:0]    w_mant;
    t_status              w_status;

    assign w_is_last = (r_col >= r_last_col);
    assign o_pop     = i_tok_valid & (~r_valid | o_field.ready);
    assign w_cand    = (ACC_EXT_W'(r_acc) << 3) + (ACC_EXT_W'(r_acc) << 1)
                     + ACC_EXT_W'(i_tok.digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_last_col <= '0;
            end else if (i_cfg_data > CFG_W'(MAX_COLUMNS)) begin
                r_last_col <= COL_W'(MAX_COLUMNS - 1);
            end else begin
                r_last_col <= COL_W'(i_cfg_data - CFG_W'(1));
            end
        end
    end

    always_comb begin
        n_col          = r_col;
        n_acc          = r_acc;
        n_frac         = r_frac;
        n_neg          = r_neg;
        n_in_frac      = r_in_frac;
        n_started      = r_started;
        n_first_t      = r_first_t;
        n_err_sat      = r_err_sat;
        n_err_bad      = r_err_bad;
        w_emit         = 1'b0;
        w_emit_bool    = 1'b0;
        w_emit_short   = 1'b0;
        w_emit_row_end = 1'b0;

        if (o_pop) begin
            if (i_tok.cls == TK_EOF) begin
                w_emit         = r_started | (r_col != '0);
                w_emit_bool    = w_is_last;
                w_emit_short   = ~w_is_last;
                w_emit_row_end = 1'b1;
                n_col          = '0;
            end else if (w_is_last) begin
                if (i_tok.cls == TK_NEWLINE) begin
                    w_emit         = 1'b1;
                    w_emit_bool    = 1'b1;
                    w_emit_row_end = 1'b1;
                    n_col          = '0;
                end else begin
                    if (!r_started) begin
                        n_first_t = i_tok.is_t;
                    end
                    n_started = 1'b1;
                end
            end else begin
                n_started = 1'b1;
                unique case (i_tok.cls)
                    TK_COMMA: begin
                        w_emit = 1'b1;
                        n_col  = r_col + COL_W'(1);
                    end
                    TK_NEWLINE: begin
                        w_emit         = 1'b1;
                        w_emit_short   = 1'b1;
                        w_emit_row_end = 1'b1;
                        n_col          = '0;
                    end
                    TK_MINUS: begin
                        if (!r_started) begin
                            n_neg = 1'b1;
                        end else begin
                            n_err_bad = 1'b1;
                        end
                    end
                    TK_POINT: begin
                        if (!r_in_frac) begin
                            n_in_frac = 1'b1;
                        end else begin
                            n_err_bad = 1'b1;
                        end
                    end
                    TK_DIGIT: begin
                        if (!r_err_sat) begin
                            if (r_in_frac && r_frac >= FRAC_W'(MAX_FRAC_DIGITS)) begin
                                n_err_sat = 1'b1;
                            end else if (w_cand > ACC_EXT_W'(MAG_LIMIT)) begin
                                n_acc     = MAG_LIMIT;
                                n_err_sat = 1'b1;
                            end else begin
                                n_acc = w_cand[MANT_W-1:0];
                                if (r_in_frac) begin
                                    n_frac = r_frac + FRAC_W'(1);
                                end
                            end
                        end
                    end
                    default: begin
                        n_err_bad = 1'b1;
                    end
                endcase
            end

            // a closed field or end of input starts a fresh field
            if (i_tok.cls == TK_EOF || i_tok.cls == TK_NEWLINE
                    || (i_tok.cls == TK_COMMA && !w_is_last)) begin
                n_acc     = '0;
                n_frac    = '0;
                n_neg     = 1'b0;
                n_in_frac = 1'b0;
                n_started = 1'b0;
                n_first_t = 1'b0;
                n_err_sat = 1'b0;
                n_err_bad = 1'b0;
            end
        end

        if (w_emit_bool) begin
            w_mant = MANT_W'(r_first_t);
        end else if (r_neg) begin
            w_mant = -r_acc;
        end else begin
            w_mant = r_acc;
        end

        if (w_emit_bool) begin
            w_status = ST_OK;
        end else if (w_emit_short) begin
            w_status = ST_SHORT;
        end else if (r_err_bad) begin
            w_status = ST_BAD;
        end else if (r_err_sat) begin
            w_status = ST_SAT;
        end else begin
            w_status = ST_OK;
        end

        if (o_pop && w_emit) begin
            n_valid = 1'b1;
        end else if (o_field.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_acc     <= '0;
            r_frac    <= '0;
            r_neg     <= 1'b0;
            r_in_frac <= 1'b0;
            r_started <= 1'b0;
            r_first_t <= 1'b0;
            r_err_sat <= 1'b0;
            r_err_bad <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_acc     <= n_acc;
            r_frac    <= n_frac;
            r_neg     <= n_neg;
            r_in_frac <= n_in_frac;
            r_started <= n_started;
            r_first_t <= n_first_t;
            r_err_sat <= n_err_sat;
            r_err_bad <= n_err_bad;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_mant     <= $signed(w_mant);
            r_frac_out <= w_emit_bool ? '0 : r_frac;
            r_col_out  <= r_col;
            r_row_end  <= w_emit_row_end;
            r_status   <= w_status;
        end
    end

    assign o_field.valid        = r_valid;
    assign o_field.mantissa     = r_mant;
    assign o_field.frac_digits  = r_frac_out;
    assign o_field.column_index = r_col_out;
    assign o_field.row_end      = r_row_end;
    assign o_field.status       = r_status;

endmodule

`default_nettype wire

FILE: hdl/csv_decimal_field_parser.sv
// top level of the csv decimal field parser
//
// i_byte carries one text byte or an end-of-input mark per transaction
// (kind 1 = end of input). o_field carries one parsed field per transaction:
// mantissa and frac_digits for numeric columns, 0 or 1 for the last column,
// with column_index, row_end and status.
// i_cfg_we / i_cfg_data write col_count; write only while the block is idle.
// throughput: one byte per cycle, sustained, while o_field is taken.
// the byte that closes a field is registered in the token queue, and its
// result is then registered by the accumulate-and-emit stage.
// the back stage does one multiply-by-ten and add per byte.
// a four-entry token queue sits between classifier and accumulator, so when
// o_field stalls up to four more transactions are taken on i_byte before
// i_byte.ready drops; the pending result holds in the output register.
// reset: col_count returns to 1, column and field state clear, queue empties.
`default_nettype none
`include "csv_decimal_field_parser_assert.svh"

module csv_decimal_field_parser
    import csvdfp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    csvdfp_in_if.sink             i_byte,
    csvdfp_out_if.source          o_field
);

    logic             w_push;
    logic             w_push_ready;
    t_token           w_push_tok;
    logic             w_pop;
    t_token           w_pop_tok;
    logic             w_tok_valid;
    logic [CNT_W-1:0] w_fifo_count;
    logic [CNT_W-1:0] w_fifo_inc;
    logic             w_short_out;
    logic             w_grow;
    logic             w_both;

    csvdfp_front u_front (
        .i_byte       (i_byte),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_tok        (w_push_tok)
    );

    csvdfp_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_tok        (w_push_tok),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_tok        (w_pop_tok),
        .o_tok_valid  (w_tok_valid),
        .o_count      (w_fifo_count)
    );

    csvdfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_tok       (w_pop_tok),
        .i_tok_valid (w_tok_valid),
        .o_pop       (w_pop),
        .o_field     (o_field)
    );

    assign w_short_out = o_field.valid && (o_field.status == ST_SHORT);
    assign w_grow      = w_push && !w_pop;
    assign w_both      = w_push && w_pop;
    assign w_fifo_inc  = w_fifo_count + CNT_W'(1);

    `CSVDFP_ASSERT_NOW(a_short_ends_row, i_clk, i_rst_n, w_short_out, o_field.row_end)
    `CSVDFP_ASSERT_NEXT(a_fifo_grows, i_clk, i_rst_n, w_grow, w_fifo_count == $past(w_fifo_inc))
    `CSVDFP_ASSERT_NEXT(a_fifo_holds, i_clk, i_rst_n, w_both, w_fifo_count == $past(w_fifo_count))

endmodule

`default_nettype wire
